[hdl/brld_pkg.sv]
// ----------------------------------------------------------------------------
// brld_pkg
// Shared types and constants for the byte run-length decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package brld_pkg;

    // decoder phase
    typedef enum logic [1:0] {
        PH_HEADER   = 2'd0,
        PH_LITERAL  = 2'd1,
        PH_REPEAT   = 2'd2,
        PH_FINISHED = 2'd3
    } phase_t;

    // configuration register indexes
    localparam logic CFG_RAW_SIZE    = 1'b0;
    localparam logic CFG_PACKED_SIZE = 1'b1;

    // header bytes at or above this value announce a repeat run
    localparam logic [7:0] REPEAT_BASE = 8'd128;

    // one result item
    typedef struct packed {
        logic [7:0] value_byte;
        logic [7:0] run_length;
        logic       done_res;
        logic       error;
    } result_t;

endpackage : brld_pkg

`default_nettype wire

[hdl/brld_in_reg.sv]
// ----------------------------------------------------------------------------
// brld_in_reg
// Input register stage: holds one packed byte until the decode stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module brld_in_reg (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_packed_byte,
    input  wire logic       take,
    output logic            item_valid,
    output logic [7:0]      item_byte
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       load;

    // accept a new byte when empty or when the held byte leaves this cycle
    assign s_ready    = !valid_reg || take;
    assign load       = s_valid && s_ready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= s_packed_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule : brld_in_reg

`default_nettype wire

[hdl/brld_core.sv]
// ----------------------------------------------------------------------------
// brld_core
// Decode stage: header parsing, size checks, run counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module brld_core
    import brld_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        item_valid,
    input  wire logic [7:0]  item_byte,
    output logic             take,
    output logic             res_valid,
    output result_t          res,
    input  wire logic        res_ready
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  literal_left_reg, literal_left_next;
    logic [7:0]  repeat_count_reg, repeat_count_next;
    logic [31:0] consumed_reg, consumed_next;
    logic [31:0] produced_reg, produced_next;
    logic [31:0] raw_size_reg, raw_size_next;
    logic [31:0] packed_size_reg, packed_size_next;
    logic        res_valid_reg, res_valid_next;
    result_t     res_reg, res_next;

    logic        emit;
    result_t     res_comb;
    logic [32:0] consumed_inc;
    logic [7:0]  count;
    logic [32:0] lit_packed_end;
    logic [32:0] run_raw_end;
    logic        complete;
    logic [7:0]  run_value;
    logic [7:0]  run_len;

    // decode stage moves when the result register is free or being drained
    assign take = item_valid && (!res_valid_reg || res_ready);

    // header run count: h+1 for literals, 257-h for repeats
    assign count = (item_byte < REPEAT_BASE) ? (item_byte + 8'd1) : (~item_byte + 8'd2);
    assign consumed_inc   = {1'b0, consumed_reg} + 33'd1;
    assign lit_packed_end = consumed_inc + {25'd0, count};
    assign run_raw_end    = {1'b0, produced_reg} + {25'd0, count};

    // decode logic for one packed byte
    always_comb begin
        phase_next        = phase_reg;
        literal_left_next = literal_left_reg;
        repeat_count_next = repeat_count_reg;
        consumed_next     = consumed_reg;
        produced_next     = produced_reg;
        emit              = 1'b0;
        res_comb          = '0;
        complete          = 1'b0;
        run_value         = item_byte;
        run_len           = 8'd0;
        case (phase_reg)
            PH_HEADER: begin
                if (produced_reg >= raw_size_reg) begin
                    phase_next        = PH_FINISHED;
                    emit              = 1'b1;
                    res_comb.done_res = 1'b1;
                end else if (consumed_reg >= packed_size_reg) begin
                    phase_next        = PH_FINISHED;
                    emit              = 1'b1;
                    res_comb.done_res = 1'b1;
                    res_comb.error    = 1'b1;
                end else begin
                    consumed_next = consumed_inc[31:0];
                    if (item_byte < REPEAT_BASE) begin
                        if (lit_packed_end > {1'b0, packed_size_reg} ||
                            run_raw_end > {1'b0, raw_size_reg}) begin
                            phase_next        = PH_FINISHED;
                            emit              = 1'b1;
                            res_comb.done_res = 1'b1;
                            res_comb.error    = 1'b1;
                        end else begin
                            literal_left_next = count;
                            phase_next        = PH_LITERAL;
                        end
                    end else begin
                        if (consumed_inc >= {1'b0, packed_size_reg} ||
                            run_raw_end > {1'b0, raw_size_reg}) begin
                            phase_next        = PH_FINISHED;
                            emit              = 1'b1;
                            res_comb.done_res = 1'b1;
                            res_comb.error    = 1'b1;
                        end else begin
                            repeat_count_next = count;
                            phase_next        = PH_REPEAT;
                        end
                    end
                end
            end
            PH_LITERAL: begin
                consumed_next     = consumed_reg + 32'd1;
                produced_next     = produced_reg + 32'd1;
                literal_left_next = literal_left_reg - 8'd1;
                complete          = (literal_left_next == 8'd0);
                run_len           = 8'd1;
                emit              = 1'b1;
            end
            PH_REPEAT: begin
                consumed_next     = consumed_reg + 32'd1;
                produced_next     = produced_reg + {24'd0, repeat_count_reg};
                repeat_count_next = 8'd0;
                complete          = 1'b1;
                run_len           = repeat_count_reg;
                emit              = 1'b1;
            end
            default: begin
                // finished stream: bytes are dropped
            end
        endcase

        // run result and end-of-stream check
        if (phase_reg == PH_LITERAL || phase_reg == PH_REPEAT) begin
            res_comb.value_byte = run_value;
            res_comb.run_length = run_len;
            if (complete) begin
                phase_next = PH_HEADER;
                if (produced_next >= raw_size_reg) begin
                    phase_next        = PH_FINISHED;
                    res_comb.done_res = 1'b1;
                end else if (consumed_next >= packed_size_reg) begin
                    phase_next        = PH_FINISHED;
                    res_comb.done_res = 1'b1;
                    res_comb.error    = 1'b1;
                end
            end
        end
    end

    // result register update
    always_comb begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (res_valid_reg && res_ready) begin
            res_valid_next = 1'b0;
        end
        if (take && emit) begin
            res_valid_next = 1'b1;
            res_next       = res_comb;
        end
    end

    // configuration writes
    always_comb begin
        raw_size_next    = raw_size_reg;
        packed_size_next = packed_size_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_RAW_SIZE:    raw_size_next    = cfg_data;
                CFG_PACKED_SIZE: packed_size_next = cfg_data;
                default:         raw_size_next    = raw_size_reg;
            endcase
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            literal_left_reg <= 8'd0;
            repeat_count_reg <= 8'd0;
            consumed_reg     <= 32'd0;
            produced_reg     <= 32'd0;
            raw_size_reg     <= 32'd0;
            packed_size_reg  <= 32'd0;
            res_valid_reg    <= 1'b0;
        end else begin
            raw_size_reg    <= raw_size_next;
            packed_size_reg <= packed_size_next;
            res_valid_reg   <= res_valid_next;
            if (cfg_we && cfg_index == CFG_RAW_SIZE) begin
                // re-arm the decoder
                phase_reg        <= PH_HEADER;
                literal_left_reg <= 8'd0;
                repeat_count_reg <= 8'd0;
                consumed_reg     <= 32'd0;
                produced_reg     <= 32'd0;
            end else if (take) begin
                phase_reg        <= phase_next;
                literal_left_reg <= literal_left_next;
                repeat_count_reg <= repeat_count_next;
                consumed_reg     <= consumed_next;
                produced_reg     <= produced_next;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule : brld_core

`default_nettype wire

[hdl/byte_run_length_decoder.sv]
// each repeat run leaves as one descriptor, each literal byte as its own descriptor
// throughput: one packed byte per cycle while m_ready drains results
// the rate is set by the single decode stage between input and result registers
// reset: synchronous active-low aresetn clears sizes, counters and both stages
// ----------------------------------------------------------------------------
// byte_run_length_decoder
// Decodes a packbits-style byte stream into run descriptors with end status.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_run_length_decoder
    import brld_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_packed_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_value_byte,
    output logic [7:0]       m_run_length,
    output logic             m_done_res,
    output logic             m_error
);

    logic       take;
    logic       item_valid;
    logic [7:0] item_byte;
    result_t    res;

    // input register stage
    brld_in_reg u_in_reg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_packed_byte (s_packed_byte),
        .take          (take),
        .item_valid    (item_valid),
        .item_byte     (item_byte)
    );

    // decode stage with result register
    brld_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .take       (take),
        .res_valid  (m_valid),
        .res        (res),
        .res_ready  (m_ready)
    );

    assign m_value_byte = res.value_byte;
    assign m_run_length = res.run_length;
    assign m_done_res   = res.done_res;
    assign m_error      = res.error;

endmodule : byte_run_length_decoder

`default_nettype wire
